/* hdl/tffr_pkg.sv */
// Package: widths, CORDIC constants and helpers for the tire force frame rotation unit.
`default_nettype none

package tffr_pkg;

    localparam int CORDIC_ITERATIONS = 16;

    localparam int FW        = 32;             // force width
    localparam int AGW       = 16;             // angle width, Q2.13
    localparam int ANG_SHIFT = 17;             // Q2.13 -> Q.30
    localparam int ZW        = 34;             // residual angle, Q.30
    localparam int CW        = 33;             // CORDIC x/y, Q.30
    localparam int QF        = 30;             // fraction bits of sin/cos
    localparam int PW        = FW + CW;        // force * trig product
    localparam int AW        = 34;             // camber-stage y/z, Q25.8
    localparam int PW2       = AW + CW;        // second-stage product
    localparam int WW        = PW2 + 1 - QF;   // rounded final value before saturation

    localparam int PIPE   = CORDIC_ITERATIONS + 5;  // stages ahead of the output register
    localparam int ST_MUL2 = PIPE - 1;

    localparam logic signed [ZW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [CW-1:0] Q30_GAIN    = 33'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_Q30 [0:31] = '{
        34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
        34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
        34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
        34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
        34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
        34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F,
        34'sh00000003F, 34'sh00000001F, 34'sh00000000F, 34'sh000000008,
        34'sh000000004, 34'sh000000002, 34'sh000000001, 34'sh000000000
    };

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_prerot;

    // Widen to Q.30 and fold angles beyond +-pi/2 by +-pi.
    function automatic t_prerot prerot(input logic signed [AGW-1:0] a);
        logic signed [ZW-1:0] zw;
        t_prerot              res;
        zw = {{(ZW-AGW-ANG_SHIFT){a[AGW-1]}}, a, {ANG_SHIFT{1'b0}}};
        res.z    = zw;
        res.flip = 1'b0;
        if (zw > Q30_HALF_PI) begin
            res.z    = zw - Q30_PI;
            res.flip = 1'b1;
        end else if (zw < -Q30_HALF_PI) begin
            res.z    = zw + Q30_PI;
            res.flip = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [FW-1:0] sat_force(input logic signed [WW-1:0] v);
        logic [FW-1:0] res;
        if ((&v[WW-1:FW-1]) || !(|v[WW-1:FW-1])) begin
            res = v[FW-1:0];
        end else if (v[WW-1]) begin
            res = {1'b1, {(FW-1){1'b0}}};
        end else begin
            res = {1'b0, {(FW-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hdl/tire_force_frame_rotation_unit.sv */
// Top level: pipelined camber-roll then steer-yaw rotation of a tire force vector.
`default_nettype none

// Accepts one force vector with its steer and camber angles per clock while ready is
// high and returns the world-frame force; the angles are folded into an input register,
// each CORDIC iteration owns one pipeline stage, both angles run side by side, followed by
// flip, multiply, round, multiply and round/saturate stages. A two-entry output
// (register plus skid) keeps input ready registered; ready drops only while the skid
// entry holds a result that the sink has not taken.
module tire_force_frame_rotation_unit
    import tffr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_axis_tvalid,
    output      logic             o_s_axis_tready,
    // force_x, force_y, force_z, yaw_ang, roll_ang
    input  wire logic [127:0]     i_s_axis_tdata,
    output      logic             o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    // world_x, world_y, world_z
    output      logic [3*FW-1:0]  o_m_axis_tdata
);

    localparam int N = CORDIC_ITERATIONS;

    logic [PIPE-1:0] r_vld;
    logic            r_out_vld;
    logic            r_skid_vld;
    logic [3*FW-1:0] r_out_data;
    logic [3*FW-1:0] r_skid_data;

    logic signed [ZW-1:0] r_cz [0:N];
    logic signed [ZW-1:0] r_sz [0:N];
    logic signed [CW-1:0] r_cx [0:N];
    logic signed [CW-1:0] r_cy [0:N];
    logic signed [CW-1:0] r_sx [0:N];
    logic signed [CW-1:0] r_sy [0:N];
    logic                 r_cflip [0:N];
    logic                 r_sflip [0:N];
    logic signed [FW-1:0] r_fx [0:N];
    logic signed [FW-1:0] r_fy [0:N];
    logic signed [FW-1:0] r_fz [0:N];

    // flip stage
    logic signed [CW-1:0] r_cos_c, r_sin_c, r_cos_s1, r_sin_s1;
    logic signed [FW-1:0] r_fx1, r_fy1, r_fz1;
    // first multiply stage
    logic signed [PW-1:0] r_p_fycc, r_p_fzsc, r_p_fysc, r_p_fzcc;
    logic signed [CW-1:0] r_cos_s2, r_sin_s2;
    logic signed [FW-1:0] r_fx2;
    // first round stage
    logic signed [AW-1:0] r_ay, r_az3;
    logic signed [CW-1:0] r_cos_s3, r_sin_s3;
    logic signed [FW-1:0] r_fx3;
    // second multiply stage
    logic signed [PW2-1:0] r_p_fxcs, r_p_ayss, r_p_fxss, r_p_aycs;
    logic signed [AW-1:0]  r_az4;

    logic w_en;
    logic w_out_ld;
    logic w_push;

    t_prerot w_pre_c, w_pre_s;

    logic signed [PW:0]    w_sum_y, w_sum_z, w_rnd_y, w_rnd_z;
    logic signed [PW2:0]   w_sum_wx, w_sum_wy, w_rnd_wx, w_rnd_wy;
    logic signed [WW-1:0]  w_wx, w_wy, w_wz;
    logic [3*FW-1:0]       w_result;

    assign w_en            = !r_skid_vld;
    assign o_s_axis_tready = w_en;
    assign w_out_ld        = !r_out_vld || i_m_axis_tready;
    assign w_push          = w_en && r_vld[ST_MUL2];

    assign w_pre_s = prerot(i_s_axis_tdata[111:96]);
    assign w_pre_c = prerot(i_s_axis_tdata[127:112]);

    always_comb begin
        w_sum_y  = (PW+1)'(r_p_fycc) - (PW+1)'(r_p_fzsc);
        w_sum_z  = (PW+1)'(r_p_fysc) + (PW+1)'(r_p_fzcc);
        w_rnd_y  = w_sum_y + $signed({{(PW+1-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}});
        w_rnd_z  = w_sum_z + $signed({{(PW+1-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}});
        w_sum_wx = (PW2+1)'(r_p_fxcs) - (PW2+1)'(r_p_ayss);
        w_sum_wy = (PW2+1)'(r_p_fxss) + (PW2+1)'(r_p_aycs);
        w_rnd_wx = w_sum_wx + $signed({{(PW2+1-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}});
        w_rnd_wy = w_sum_wy + $signed({{(PW2+1-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}});
        w_wx     = w_rnd_wx[PW2:QF];
        w_wy     = w_rnd_wy[PW2:QF];
        w_wz     = WW'(r_az4);
        w_result = {sat_force(w_wz), sat_force(w_wy), sat_force(w_wx)};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[PIPE-2:0], i_s_axis_tvalid};
            end
            if (w_out_ld) begin
                r_out_vld  <= r_skid_vld || w_push;
                r_skid_vld <= 1'b0;
            end else if (w_push) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cz[0]    <= w_pre_c.z;
            r_cflip[0] <= w_pre_c.flip;
            r_sz[0]    <= w_pre_s.z;
            r_sflip[0] <= w_pre_s.flip;
            r_cx[0]    <= Q30_GAIN;
            r_cy[0]    <= '0;
            r_sx[0]    <= Q30_GAIN;
            r_sy[0]    <= '0;
            r_fx[0]    <= i_s_axis_tdata[31:0];
            r_fy[0]    <= i_s_axis_tdata[63:32];
            r_fz[0]    <= i_s_axis_tdata[95:64];

            for (int i = 0; i < N; i++) begin
                r_cflip[i+1] <= r_cflip[i];
                r_sflip[i+1] <= r_sflip[i];
                r_fx[i+1]    <= r_fx[i];
                r_fy[i+1]    <= r_fy[i];
                r_fz[i+1]    <= r_fz[i];
                if (r_cz[i] >= 0) begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - ATAN_Q30[i];
                end else begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + ATAN_Q30[i];
                end
                if (r_sz[i] >= 0) begin
                    r_sx[i+1] <= r_sx[i] - (r_sy[i] >>> i);
                    r_sy[i+1] <= r_sy[i] + (r_sx[i] >>> i);
                    r_sz[i+1] <= r_sz[i] - ATAN_Q30[i];
                end else begin
                    r_sx[i+1] <= r_sx[i] + (r_sy[i] >>> i);
                    r_sy[i+1] <= r_sy[i] - (r_sx[i] >>> i);
                    r_sz[i+1] <= r_sz[i] + ATAN_Q30[i];
                end
            end

            r_cos_c  <= r_cflip[N] ? -r_cx[N] : r_cx[N];
            r_sin_c  <= r_cflip[N] ? -r_cy[N] : r_cy[N];
            r_cos_s1 <= r_sflip[N] ? -r_sx[N] : r_sx[N];
            r_sin_s1 <= r_sflip[N] ? -r_sy[N] : r_sy[N];
            r_fx1    <= r_fx[N];
            r_fy1    <= r_fy[N];
            r_fz1    <= r_fz[N];

            r_p_fycc <= r_fy1 * r_cos_c;
            r_p_fzsc <= r_fz1 * r_sin_c;
            r_p_fysc <= r_fy1 * r_sin_c;
            r_p_fzcc <= r_fz1 * r_cos_c;
            r_cos_s2 <= r_cos_s1;
            r_sin_s2 <= r_sin_s1;
            r_fx2    <= r_fx1;

            r_ay     <= w_rnd_y[QF+AW-1:QF];
            r_az3    <= w_rnd_z[QF+AW-1:QF];
            r_cos_s3 <= r_cos_s2;
            r_sin_s3 <= r_sin_s2;
            r_fx3    <= r_fx2;

            r_p_fxcs <= r_fx3 * r_cos_s3;
            r_p_ayss <= r_ay * r_sin_s3;
            r_p_fxss <= r_fx3 * r_sin_s3;
            r_p_aycs <= r_ay * r_cos_s3;
            r_az4    <= r_az3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_out_data <= r_skid_vld ? r_skid_data : w_result;
        end else if (w_push) begin
            r_skid_data <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_m_axis_tready))
        else $error("skid entry filled without an output stall");

    a_prerot_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_cz[0] <= Q30_HALF_PI && r_cz[0] >= -Q30_HALF_PI &&
                      r_sz[0] <= Q30_HALF_PI && r_sz[0] >= -Q30_HALF_PI))
        else $error("pre-rotated angle outside CORDIC reach");
`endif

endmodule

`default_nettype wire
